### sv/mfr_pkg.sv
// Shared types and constants for the marker frame receiver.
// No dependencies; imported by mfr_core and marker_frame_receiver_top.
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;

  localparam int BUFFER_SIZE_DEF = 256;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  localparam logic [1:0] RUN_CLOSE = 2'd3;
  localparam int         TRIM_LEN  = 6;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] byte_count;
    logic       hit;
  } res_t;

endpackage
`default_nettype wire

### sv/mfr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the frame buffer.
`timescale 1ns / 1ps
`default_nettype none
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/mfr_core.sv
// Frame state of the receiver: count, ready flag, marker streaks, last two bytes.
// Depends on mfr_pkg; drives the buffer RAM port and the next result.
`timescale 1ns / 1ps
`default_nettype none
module mfr_core #(
  parameter int BUFFER_SIZE = mfr_pkg::BUFFER_SIZE_DEF,
  localparam int AW = $clog2(BUFFER_SIZE)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [1:0]   op_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic [7:0]   read_index_i,
  output      logic         ram_we_o,
  output      logic         ram_re_o,
  output      logic [AW-1:0] ram_addr_o,
  output      logic [7:0]   ram_wdata_o,
  output      mfr_pkg::res_t res_o
);
  import mfr_pkg::*;

  localparam int CW = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] CAP  = AW'(BUFFER_SIZE - 1);
  localparam logic [AW-1:0] TRIM = AW'(TRIM_LEN);

  logic [AW-1:0] fill_q, fill_d;
  logic          ready_q, ready_d;
  logic [1:0]    raw_q, raw_d;
  logic [1:0]    hex_q, hex_d;
  logic [7:0]    last1_q, last2_q;
  logic          store;
  logic          hit;

  always_comb begin
    logic [AW-1:0] fill_inc;
    logic [7:0]    hi;
    logic [7:0]    lo;
    logic [1:0]    hex_inc;
    fill_d   = fill_q;
    ready_d  = ready_q;
    raw_d    = raw_q;
    hex_d    = hex_q;
    store    = 1'b0;
    fill_inc = fill_q;
    hi       = last2_q;
    lo       = last1_q;
    hex_inc  = hex_q + 2'd1;
    hit      = CW'(read_index_i) < CW'(fill_q);
    unique case (op_e'(op_i))
      OP_RECV: begin
        if (data_byte_i == CH_START) begin
          fill_d  = '0;
          ready_d = 1'b0;
          raw_d   = '0;
          hex_d   = '0;
        end else if (data_byte_i == CH_STAR) begin
          if (raw_q != RUN_CLOSE) begin
            raw_d = raw_q + 2'd1;
          end
          if (raw_d == RUN_CLOSE && fill_q != '0) begin
            ready_d = 1'b1;
          end
        end else begin
          raw_d = '0;
          store = fill_q < CAP;
          if (store) begin
            fill_inc = fill_q + AW'(1);
            hi       = last1_q;
            lo       = data_byte_i;
          end
          fill_d = fill_inc;
          if (fill_inc >= AW'(2) && !fill_inc[0]) begin
            if (hi == CH_TWO && (lo == CH_UA || lo == CH_LA)) begin
              if (hex_inc == RUN_CLOSE) begin
                fill_d  = (fill_inc >= TRIM) ? fill_inc - TRIM : '0;
                ready_d = 1'b1;
                hex_d   = '0;
              end else begin
                hex_d = hex_inc;
              end
            end else begin
              hex_d = '0;
            end
          end
        end
      end
      OP_CLEAR: begin
        fill_d  = '0;
        ready_d = 1'b0;
        raw_d   = '0;
        hex_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ready_q <= 1'b0;
      raw_q   <= '0;
      hex_q   <= '0;
    end else if (accept_i) begin
      fill_q  <= fill_d;
      ready_q <= ready_d;
      raw_q   <= raw_d;
      hex_q   <= hex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we_o) begin
      last2_q <= last1_q;
      last1_q <= data_byte_i;
    end
  end

  assign ram_we_o    = accept_i && (op_i == OP_RECV) && store;
  assign ram_re_o    = accept_i && (op_i == OP_READ);
  assign ram_addr_o  = (op_i == OP_RECV) ? fill_q : AW'(read_index_i);
  assign ram_wdata_o = data_byte_i;

  assign res_o.frame_ready = ready_d;
  assign res_o.byte_count  = 8'(fill_d);
  assign res_o.hit         = (op_i == OP_READ) && hit;

endmodule
`default_nettype wire

### sv/marker_frame_receiver_top.sv
// Top level of the marker frame receiver: handshake, result register, buffer RAM.
// Depends on mfr_pkg, mfr_core and mfr_ram.
//
// Input channel (in_valid_i / in_stall_o) carries one item: op_i selects
// receive byte, read buffer entry or clear. Output channel (out_valid_o /
// out_stall_i) returns one result per item: frame_ready_o, byte_count_o and
// read_data_o (buffer byte for an in-range read, else 0).
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle when the input is not stalled; the frame
// state and the buffer RAM port are updated in the accept cycle, read data
// comes from the RAM's output register alongside the result register.
// The input is stalled only while a result is held and out_stall_i is high;
// a held result and its read data stay unchanged until taken.
// Reset clears the count, the ready flag, both streaks and the output valid;
// buffer contents are not cleared, since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
module marker_frame_receiver_top #(
  parameter int BUFFER_SIZE = mfr_pkg::BUFFER_SIZE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] read_index_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic       frame_ready_o,
  output      logic [7:0] byte_count_o,
  output      logic [7:0] read_data_o
);
  import mfr_pkg::*;

  localparam int AW = $clog2(BUFFER_SIZE);

  logic          accept;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  res_t          res_d;
  res_t          res_q;
  logic          out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  mfr_core #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .read_index_i(read_index_i),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .res_o       (res_d)
  );

  mfr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_ready_o = res_q.frame_ready;
  assign byte_count_o  = res_q.byte_count;
  assign read_data_o   = res_q.hit ? ram_rdata : 8'd0;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_read_data_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_data_o != 8'd0) |-> res_q.hit)
    else $error("read data shown without an in-range read");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_CLEAR) |=> (!frame_ready_o && byte_count_o == 8'd0))
    else $error("clear left frame state behind");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire
